// ----- rtl/b64d_pkg.sv -----
`default_nettype none
package b64d_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int CAP_W = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;
	localparam logic [ADDR_W-1:0] REG_OUT_CAPACITY = 3'd0;

	localparam logic [6:0] SEXTET_MAX = 7'd63;
	localparam logic [6:0] CLS_NEWLINE = 7'd64;
	localparam logic [6:0] CLS_SPACE = 7'd65;
	localparam logic [6:0] CLS_PAD = 7'd66;
	localparam logic [6:0] CLS_BAD = 7'd67;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_SYMBOL = 3'd1;
	localparam logic [2:0] ST_BAD_ORDER = 3'd2;
	localparam logic [2:0] ST_TOO_MANY_PADS = 3'd3;
	localparam logic [2:0] ST_NO_ROOM = 3'd4;
	localparam logic [2:0] ST_PAD_BITS = 3'd5;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd6;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        done_res;
		logic [2:0]  status;
		logic [15:0] byte_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       nbytes;
		logic [2:0][7:0]  bytes;
		logic             has_status;
		logic [2:0]       status;
		logic [15:0]      byte_count;
	} grp_t;

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [6:0] cls;
		if (c >= 8'h41 && c <= 8'h5A) cls = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) cls = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39) cls = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B) cls = 7'd62;
		else if (c == 8'h2F) cls = SEXTET_MAX;
		else if (c == 8'h0A || c == 8'h0D) cls = CLS_NEWLINE;
		else if (c == 8'h20) cls = CLS_SPACE;
		else if (c == 8'h3D) cls = CLS_PAD;
		else cls = CLS_BAD;
		return cls;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/b64d_core.sv -----
`default_nettype none
module b64d_core #(
	parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire b64d_pkg::in_item_t     item,
	input  wire logic [b64d_pkg::CAP_W-1:0] capacity,
	output b64d_pkg::grp_t              grp
);
	import b64d_pkg::*;

	localparam int CW = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;

	logic [17:0]           acc_q, acc_d;
	logic [1:0]            cnt_q, cnt_d;
	logic [1:0]            pad_q, pad_d;
	logic                  space_q, space_d;
	logic [COUNT_BITS-1:0] ocnt_q, ocnt_d;
	logic                  nf_q, nf_d;
	logic                  drain_q, drain_d;

	logic [6:0]      cls;
	logic [2:0]      st;
	logic [1:0]      nb;
	logic [2:0][7:0] bytes;
	logic [23:0]     word;
	logic [CW-1:0]   cap_ext, cap_max, cap_eff, cnt_ext, sum_w;
	logic            room1, room2, room3, emit;

	assign cls = classify(item.in_char);
	assign word = {acc_q, cls[5:0]};
	assign cap_ext = CW'(capacity);
	assign cap_max = CW'({COUNT_BITS{1'b1}});
	assign cap_eff = (cap_ext > cap_max) ? cap_max : cap_ext;
	assign cnt_ext = CW'(ocnt_q);
	assign room1 = (cnt_ext + CW'(1)) <= cap_eff;
	assign room2 = (cnt_ext + CW'(2)) <= cap_eff;
	assign room3 = (cnt_ext + CW'(3)) <= cap_eff;
	assign sum_w = cnt_ext + CW'(nb);

	always_comb begin
		acc_d = acc_q;
		cnt_d = cnt_q;
		pad_d = pad_q;
		space_d = space_q;
		ocnt_d = ocnt_q;
		nf_d = nf_q;
		drain_d = drain_q;
		st = ST_OK;
		nb = 2'd0;
		bytes = '0;
		emit = 1'b0;
		if (drain_q) begin
			if (item.last) begin
				acc_d = '0;
				cnt_d = '0;
				pad_d = '0;
				space_d = 1'b0;
				ocnt_d = '0;
				nf_d = 1'b0;
				drain_d = 1'b0;
			end
		end else begin
			if (item.last && !nf_q) begin
				st = ST_BAD_LENGTH;
			end else begin
				nf_d = 1'b1;
				if (cls == CLS_BAD) begin
					st = ST_BAD_SYMBOL;
				end else if (cls == CLS_PAD) begin
					if (space_q) st = ST_BAD_ORDER;
					else if (pad_q >= 2'd2) st = ST_TOO_MANY_PADS;
					else pad_d = pad_q + 2'd1;
				end else if (cls == CLS_SPACE) begin
					space_d = 1'b1;
				end else if (cls <= SEXTET_MAX) begin
					if (space_q || pad_q != 2'd0) begin
						st = ST_BAD_ORDER;
					end else if (cnt_q < 2'd3) begin
						acc_d = {acc_q[11:0], cls[5:0]};
						cnt_d = cnt_q + 2'd1;
					end else begin
						acc_d = '0;
						cnt_d = '0;
						if (room3) begin
							bytes = {word[7:0], word[15:8], word[23:16]};
							nb = 2'd3;
						end else begin
							st = ST_NO_ROOM;
						end
					end
				end
				if (st == ST_OK && item.last) begin
					case (cnt_d)
						2'd3: begin
							if (acc_d[1:0] != 2'd0) st = ST_PAD_BITS;
							else if (!room2) st = ST_NO_ROOM;
							else begin
								bytes = {8'd0, acc_d[9:2], acc_d[17:10]};
								nb = 2'd2;
							end
						end
						2'd2: begin
							if (acc_d[3:0] != 4'd0) st = ST_PAD_BITS;
							else if (!room1) st = ST_NO_ROOM;
							else begin
								bytes = {16'd0, acc_d[11:4]};
								nb = 2'd1;
							end
						end
						2'd1: st = ST_BAD_LENGTH;
						default: st = ST_OK;
					endcase
				end
			end
			ocnt_d = sum_w[COUNT_BITS-1:0];
			emit = (st != ST_OK) || item.last;
			if (emit) begin
				if (item.last) begin
					acc_d = '0;
					cnt_d = '0;
					pad_d = '0;
					space_d = 1'b0;
					ocnt_d = '0;
					nf_d = 1'b0;
					drain_d = 1'b0;
				end else begin
					drain_d = 1'b1;
				end
			end
		end
		grp.nbytes = nb;
		grp.bytes = bytes;
		grp.has_status = emit;
		grp.status = st;
		grp.byte_count = 16'(sum_w[COUNT_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			space_q <= 1'b0;
			ocnt_q <= '0;
			nf_q <= 1'b0;
			drain_q <= 1'b0;
		end else if (take) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			pad_q <= pad_d;
			space_q <= space_d;
			ocnt_q <= ocnt_d;
			nf_q <= nf_d;
			drain_q <= drain_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/b64d_outbuf.sv -----
`default_nettype none
module b64d_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire b64d_pkg::grp_t   grp,
	output logic                  free,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output b64d_pkg::out_item_t   out_item
);
	import b64d_pkg::*;

	grp_t       grp_q;
	logic       full_q;
	logic [1:0] idx_q;
	logic [2:0] total;
	logic       final_res;
	logic       has_res;

	assign total = {1'b0, grp_q.nbytes} + {2'b0, grp_q.has_status};
	assign final_res = ({1'b0, idx_q} + 3'd1) == total;
	assign has_res = (grp.nbytes != 2'd0) || grp.has_status;
	assign free = !full_q || (out_ready && final_res);
	assign out_valid = full_q;

	always_comb begin
		if (idx_q < grp_q.nbytes) begin
			out_item.out_byte = grp_q.bytes[idx_q];
			out_item.byte_valid = 1'b1;
			out_item.done_res = 1'b0;
			out_item.status = ST_OK;
			out_item.byte_count = '0;
		end else begin
			out_item.out_byte = '0;
			out_item.byte_valid = 1'b0;
			out_item.done_res = 1'b1;
			out_item.status = grp_q.status;
			out_item.byte_count = grp_q.byte_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q <= '0;
		end else if (load && has_res) begin
			full_q <= 1'b1;
			idx_q <= '0;
		end else if (full_q && out_ready) begin
			if (final_res) full_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && has_res) grp_q <= grp;
	end

endmodule
`default_nettype wire

// ----- rtl/base64_stream_decoder_unit.sv -----
`default_nettype none
// Streaming Base64 decoder: one character per input item, decoded bytes and a final status
// as single output items. An accepted character waits in the input register until the output
// register is free, is then decoded against the stream state and loads the output register,
// from which its first result is offered. An item yielding zero or one result lets a new item
// in every cycle while the output side accepts; an item yielding n results (up to three bytes
// plus status) holds the output register for n accepted output items, so the output port
// alone sets throughput.
// out_capacity (APB address 0, reset 65535) bounds the decoded bytes of each stream.
module base64_stream_decoder_unit #(
	parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire b64d_pkg::in_item_t          in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output b64d_pkg::out_item_t              out_item,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [b64d_pkg::ADDR_W-1:0] paddr,
	input  wire logic [b64d_pkg::DATA_W-1:0] pwdata,
	output logic [b64d_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import b64d_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	logic [CAP_W-1:0] cap_q;
	logic             buf_free, advance;
	grp_t             grp;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_OUT_CAPACITY[ADDR_W-1:2]) ?
		DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite &&
				paddr[ADDR_W-1:2] == REG_OUT_CAPACITY[ADDR_W-1:2]) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign advance = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	b64d_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.item    (item_s1),
		.capacity(cap_q),
		.grp     (grp)
	);

	b64d_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.grp      (grp),
		.free     (buf_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule
`default_nettype wire
